// File: rtl/msh_pkg.sv
// ----------------------------------------------------------------------------
// msh_pkg
// Shared types, codes and defaults of the multichannel sample history block.
// ----------------------------------------------------------------------------
package msh_pkg;

  localparam int DefChannels   = 8;
  localparam int DefDepth      = 16;
  localparam int DefSampleBits = 10;

  // Stream payload widths, fixed by the transaction layout.
  localparam int InDataW  = 16;
  localparam int InUserW  = 2;
  localparam int OutDataW = 56;

  // Starting value of the running minimum.
  localparam logic [15:0] MinInit = 16'hFFFF;

  typedef enum logic [1:0] {
    ACT_SINGLE = 2'd0,
    ACT_BURST  = 2'd1,
    ACT_DONE   = 2'd2,
    ACT_QUERY  = 2'd3
  } action_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_TAIL = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_FIX  = 5'b10000
  } state_e;

endpackage

// File: rtl/msh_ram.sv
// ----------------------------------------------------------------------------
// msh_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module msh_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/multichannel_sample_history_top.sv
// ----------------------------------------------------------------------------
// multichannel_sample_history_top
// Per-channel ring of recent converter samples with ring statistics.
// ----------------------------------------------------------------------------
// Each transaction occupies the block from the cycle in which it is accepted
// until its result is loaded. That cycle decodes the transaction and, for a
// conversion done, stores the sample. Then the scan loop reads one ring entry
// per cycle through the single read port of the sample RAM until every entry
// of the ring has been read. The ST_TAIL step lets the last read land in the
// shared sum, minimum and maximum unit. The ST_MUL and ST_FIX steps do the
// reciprocal multiply and correction that form the average, and ST_FIX loads
// the result; the next transaction can be accepted in the cycle after that.
// The input is ready only while the sequencer is idle. A finished
// result waits in the output register until the downstream side takes it, and
// a result still waiting there holds the sequencer in its last step. The
// sample store reads as zero after reset without a clearing pass: each
// channel's ring fills in order, so its write position and a wrapped flag
// tell which entries hold written samples.
// ----------------------------------------------------------------------------
module multichannel_sample_history_top import msh_pkg::*; #(
  parameter int CHANNELS    = DefChannels,
  parameter int DEPTH       = DefDepth,
  parameter int SAMPLE_BITS = DefSampleBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // chan [2:0], sample [12:3], zero [15:13]
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // action [1:0]
  input  logic [InUserW-1:0]  s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // start_conversion [0], busy_res [1], newest [11:2], average [21:12],
  // high_res [33:22], minimum [43:34], maximum [53:44], zero [55:54]
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  localparam int ChW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NCh   = 1 << ChW;
  localparam int IdxW  = $clog2(DEPTH);
  localparam int AddrW = ChW + IdxW;
  localparam int SumW  = SAMPLE_BITS + IdxW;
  localparam int CntW  = $clog2(DEPTH + 1);
  localparam logic [SumW-1:0] Recip = SumW'((1 << SumW) / DEPTH);

  state_e state_q, state_d;

  // Control state.
  logic [IdxW-1:0] pos_q  [NCh];
  logic            wrap_q [NCh];
  logic [CntW-1:0] rem_q, rem_d;
  logic [ChW-1:0]  cur_ch_q;
  logic            m_tvalid_q, m_tvalid_d;
  logic            rd_vld_q;

  // Per-transaction payload.
  logic [ChW-1:0]         rep_ch_q;
  logic                   rep_bad_q;
  logic [IdxW-1:0]        rep_pos_q;
  logic                   rep_wrap_q;
  logic                   req_q;
  logic                   busy_q;
  logic [IdxW-1:0]        idx_q;
  logic [IdxW-1:0]        rd_idx_q;
  logic                   rd_ok_q;
  logic [SumW-1:0]        sum_q;
  logic [SAMPLE_BITS-1:0] min_q, max_q, newest_q;
  logic [2*SumW-1:0]      prod_q;
  logic [OutDataW-1:0]    m_tdata_q;

  // Input decode.
  action_e                in_act;
  logic [2:0]             in_chan;
  logic [9:0]             in_sample;
  logic [15:0]            sample_ext;
  logic [4:0]             chan_ext;
  logic [ChW-1:0]         chan_idx;
  logic                   chan_ok;
  logic                   accept;
  logic                   is_done, is_start;
  logic [ChW-1:0]         sel_ch;
  logic [IdxW-1:0]        sel_pos, pos_next;
  logic                   sel_wrap, pos_last;
  logic                   req_d;

  assign in_act     = action_e'(s_axis_tuser_i);
  assign in_chan    = s_axis_tdata_i[2:0];
  assign in_sample  = s_axis_tdata_i[12:3];
  assign sample_ext = {6'd0, in_sample};
  assign chan_ext   = {2'b00, in_chan};
  assign chan_idx   = chan_ext[ChW-1:0];
  assign chan_ok    = (32'(in_chan) < CHANNELS);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign is_done         = (in_act == ACT_DONE);
  assign is_start        = in_act inside {ACT_SINGLE, ACT_BURST};

  // A conversion done always goes to the active channel.
  assign sel_ch   = is_done ? cur_ch_q : chan_idx;
  assign sel_pos  = pos_q[sel_ch];
  assign sel_wrap = wrap_q[sel_ch];
  assign pos_last = (sel_pos == IdxW'(DEPTH - 1));
  assign pos_next = pos_last ? '0 : sel_pos + 1'b1;

  always_comb begin
    rem_d = rem_q;
    req_d = 1'b0;
    if (accept) begin
      if (is_start && chan_ok) begin
        rem_d = (in_act == ACT_SINGLE) ? CntW'(1) : CntW'(DEPTH);
        req_d = 1'b1;
      end else if (is_done && (rem_q != '0)) begin
        rem_d = rem_q - 1'b1;
        req_d = (rem_q != CntW'(1));
      end
    end
  end

  // Sample RAM.
  logic                   ram_we;
  logic [AddrW-1:0]       ram_waddr, ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  assign ram_we    = accept && is_done;
  assign ram_waddr = {sel_ch, sel_pos};
  assign ram_raddr = {rep_ch_q, idx_q};

  msh_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(1 << AddrW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(sample_ext[SAMPLE_BITS-1:0]),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_SCAN;
      ST_SCAN: if (idx_q == IdxW'(DEPTH - 1)) state_d = ST_TAIL;
      ST_TAIL: state_d = ST_MUL;
      ST_MUL:  state_d = ST_FIX;
      ST_FIX:  if (!m_tvalid_q || m_axis_tready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  logic load_out;
  assign load_out = (state_q == ST_FIX) && (!m_tvalid_q || m_axis_tready_i);

  always_comb begin
    m_tvalid_d = m_tvalid_q && !m_axis_tready_i;
    if (load_out) begin
      m_tvalid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rem_q      <= '0;
      cur_ch_q   <= '0;
      m_tvalid_q <= 1'b0;
      rd_vld_q   <= 1'b0;
      for (int i = 0; i < NCh; i++) begin
        pos_q[i]  <= '0;
        wrap_q[i] <= 1'b0;
      end
    end else begin
      state_q    <= state_d;
      rem_q      <= rem_d;
      m_tvalid_q <= m_tvalid_d;
      rd_vld_q   <= (state_q == ST_SCAN);
      if (accept && is_start && chan_ok) begin
        cur_ch_q <= chan_idx;
      end
      if (accept && is_done) begin
        pos_q[sel_ch] <= pos_next;
        if (pos_last) begin
          wrap_q[sel_ch] <= 1'b1;
        end
      end
    end
  end

  // Shared accumulate and compare unit, fed one ring entry per cycle.
  logic [SAMPLE_BITS-1:0] rd_val;
  logic [IdxW-1:0]        newest_idx;

  assign rd_val     = rd_ok_q ? ram_rdata : '0;
  assign newest_idx = (rep_pos_q == '0) ? IdxW'(DEPTH - 1) : rep_pos_q - 1'b1;

  // Average by reciprocal multiply; the estimate is low by at most one.
  logic [SumW-1:0]     q_est, div_rem, avg_w;
  logic [31:0]         avg32, hr32, new32, min32, max32;
  logic [OutDataW-1:0] m_tdata_d;

  assign q_est   = prod_q[2*SumW-1:SumW];
  assign div_rem = sum_q - SumW'(q_est * DEPTH);
  assign avg_w   = (div_rem >= SumW'(DEPTH)) ? q_est + 1'b1 : q_est;

  always_comb begin
    avg32 = 32'(avg_w);
    hr32  = 32'(sum_q) >> 2;
    new32 = 32'(newest_q);
    min32 = 32'(min_q);
    max32 = 32'(max_q);
    if (rep_bad_q) begin
      avg32 = '0;
      hr32  = '0;
      new32 = '0;
      min32 = '0;
      max32 = '0;
    end
    m_tdata_d = {2'b00, max32[9:0], min32[9:0], hr32[11:0], avg32[9:0],
                 new32[9:0], busy_q, req_q};
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rep_ch_q   <= sel_ch;
      rep_bad_q  <= !is_done && !chan_ok;
      rep_pos_q  <= is_done ? pos_next : sel_pos;
      rep_wrap_q <= sel_wrap || (is_done && pos_last);
      req_q      <= req_d;
      busy_q     <= (rem_d != '0);
      idx_q      <= '0;
      sum_q      <= '0;
      min_q      <= MinInit[SAMPLE_BITS-1:0];
      max_q      <= '0;
    end
    if (state_q == ST_SCAN) begin
      idx_q    <= idx_q + 1'b1;
      rd_idx_q <= idx_q;
      rd_ok_q  <= rep_wrap_q || (idx_q < rep_pos_q);
    end
    if (rd_vld_q) begin
      sum_q <= sum_q + SumW'(rd_val);
      if (rd_val < min_q) begin
        min_q <= rd_val;
      end
      if (rd_val > max_q) begin
        max_q <= rd_val;
      end
      if (rd_idx_q == newest_idx) begin
        newest_q <= rd_val;
      end
    end
    if (state_q == ST_MUL) begin
      prod_q <= sum_q * Recip;
    end
    if (load_out) begin
      m_tdata_q <= m_tdata_d;
    end
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;

endmodule

// File: rtl/msh_checker.sv
// ----------------------------------------------------------------------------
// msh_checker
// Port-level checks of the multichannel sample history block.
// ----------------------------------------------------------------------------
module msh_checker import msh_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic [InDataW-1:0]  s_axis_tdata_i,
  input logic [InUserW-1:0]  s_axis_tuser_i,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o
);

  // The block works on one transaction at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted again right after a transaction");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed or dropped");

  // A new conversion is only requested while conversions remain.
  a_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[0] && !m_axis_tdata_o[1]))
    else $error("conversion requested while not busy");

  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[43:34] <= m_axis_tdata_o[53:44]))
    else $error("minimum above maximum");

endmodule

bind multichannel_sample_history_top msh_checker u_msh_checker (.*);
